[hdl/srma_pkg.sv]
// Shared types and constants for the sparse row merge/add block.
`default_nettype none
package srma_pkg;

    localparam int C_COL_W   = 11;
    localparam int C_VAL_W   = 32;
    localparam int C_CNT_W   = 7;
    localparam int C_SUM_W   = 34;
    localparam int C_COLUMNS = 1024;

    // register index as decoded from paddr[2]
    localparam logic C_IDX_SUBTRACT = 1'b0;

    typedef enum logic [1:0] {
        S_LOAD,
        S_PRIME,
        S_MERGE,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [C_COL_W-1:0]        col;
        logic signed [C_VAL_W-1:0] val;
    } t_entry;

    typedef struct packed {
        logic [C_COL_W-1:0]        col;
        logic signed [C_VAL_W-1:0] val;
        logic                      present;
        logic                      last;
        logic [C_CNT_W-1:0]        cnt;
    } t_result;

    localparam logic signed [C_SUM_W-1:0] C_SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [C_SUM_W-1:0] C_SAT_MIN = -34'sh0_8000_0000;

endpackage
`default_nettype wire

[hdl/srma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module srma_ram #(
    parameter int WIDTH = 43,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hdl/sparse_row_merge_add.sv]
// A row-B beat with last set starts the merge via S_PRIME; each nonzero result is held, then
// goes to the output register when a later nonzero result arrives, or at flush as the last.
// Throughput: load takes one beat per cycle; the merge walks one column step per cycle through
// the registered row-RAM reads. The single output register and one held result stall the walk
// while results go untaken.
// Reset (i_rst_n low, synchronous) clears counts, pointers, state and subtract mode;
// row RAM contents are not cleared, only entries below the counts are read.
`default_nettype none
module sparse_row_merge_add #(
    parameter int ROW_CAPACITY = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // APB-style configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    // input beats
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_source,
    input  wire logic [srma_pkg::C_COL_W-1:0] i_column,
    input  wire logic signed [srma_pkg::C_VAL_W-1:0] i_value,
    input  wire logic                         i_present,
    input  wire logic                         i_last,
    // result beats
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [srma_pkg::C_COL_W-1:0] o_out_column,
    output logic signed [srma_pkg::C_VAL_W-1:0] o_out_value,
    output logic                              o_out_present,
    output logic                              o_out_last,
    output logic      [srma_pkg::C_CNT_W-1:0] o_out_count
);

    localparam int AW = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
    localparam int CW = $clog2(ROW_CAPACITY + 1);
    localparam int EW = $bits(srma_pkg::t_entry);
    localparam logic [CW-1:0] CAP = CW'(ROW_CAPACITY);

    srma_pkg::t_state r_state, n_state;

    logic          r_sub;
    logic [CW-1:0] r_acnt, n_acnt, r_bcnt, n_bcnt;
    logic [CW-1:0] r_ai, n_ai, r_bi, n_bi;
    logic [srma_pkg::C_CNT_W-1:0] r_emit, n_emit;
    logic          r_hold_v, n_hold_v;
    srma_pkg::t_result r_hold, n_hold;
    logic          r_ov, n_ov;
    srma_pkg::t_result r_out, n_out;

    // control from the state decode
    logic in_ready, mrg_act, fl_act;

    logic          accept, keep, we_a, we_b, out_free;
    srma_pkg::t_entry wentry, rd_a, rd_b;
    logic [EW-1:0] rd_a_raw, rd_b_raw;

    logic a_ok, b_ok, take_a, take_b, mrg_go, nz;
    logic signed [srma_pkg::C_SUM_W-1:0] a_ext, b_ext, a_term, b_term, sum;
    logic signed [srma_pkg::C_VAL_W-1:0] sat_val;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == srma_pkg::C_IDX_SUBTRACT) ? {31'd0, r_sub} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == srma_pkg::C_IDX_SUBTRACT) begin
            r_sub <= pwdata[0];
        end
    end

    // ---------------- load side ----------------
    assign accept = i_in_valid && o_in_ready;
    assign keep   = i_present && (i_column != '0)
                    && (32'(i_column) <= 32'(srma_pkg::C_COLUMNS));
    assign we_a   = accept && keep && !i_source && (r_acnt < CAP);
    assign we_b   = accept && keep &&  i_source && (r_bcnt < CAP);
    assign wentry = '{col: i_column, val: i_value};

    srma_ram #(.WIDTH(EW), .DEPTH(ROW_CAPACITY)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_acnt[AW-1:0]),
        .i_wdata (wentry),
        .i_raddr (n_ai[AW-1:0]),
        .o_rdata (rd_a_raw)
    );

    srma_ram #(.WIDTH(EW), .DEPTH(ROW_CAPACITY)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_bcnt[AW-1:0]),
        .i_wdata (wentry),
        .i_raddr (n_bi[AW-1:0]),
        .o_rdata (rd_b_raw)
    );

    assign rd_a = srma_pkg::t_entry'(rd_a_raw);
    assign rd_b = srma_pkg::t_entry'(rd_b_raw);

    // ---------------- merge datapath ----------------
    assign out_free = !r_ov || i_out_ready;
    assign a_ok     = r_ai < r_acnt;
    assign b_ok     = r_bi < r_bcnt;
    assign take_a   = a_ok && (!b_ok || rd_a.col <= rd_b.col);
    assign take_b   = b_ok && (!a_ok || rd_b.col <= rd_a.col);
    assign mrg_go   = mrg_act && (a_ok || b_ok) && (!r_hold_v || out_free);

    assign a_ext  = srma_pkg::C_SUM_W'(rd_a.val);
    assign b_ext  = srma_pkg::C_SUM_W'(rd_b.val);
    assign a_term = take_a ? a_ext : '0;
    assign b_term = !take_b ? '0 : (r_sub ? -b_ext : b_ext);
    assign sum    = a_term + b_term;
    assign nz     = sum != '0;

    always_comb begin
        if (sum > srma_pkg::C_SAT_MAX) begin
            sat_val = srma_pkg::C_SAT_MAX[srma_pkg::C_VAL_W-1:0];
        end else if (sum < srma_pkg::C_SAT_MIN) begin
            sat_val = srma_pkg::C_SAT_MIN[srma_pkg::C_VAL_W-1:0];
        end else begin
            sat_val = sum[srma_pkg::C_VAL_W-1:0];
        end
    end

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            srma_pkg::S_LOAD: begin
                if (accept && i_source && i_last) n_state = srma_pkg::S_PRIME;
            end
            srma_pkg::S_PRIME: n_state = srma_pkg::S_MERGE;
            srma_pkg::S_MERGE: begin
                if (!a_ok && !b_ok) n_state = srma_pkg::S_FLUSH;
            end
            srma_pkg::S_FLUSH: begin
                if (out_free) n_state = srma_pkg::S_LOAD;
            end
            default: n_state = srma_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        mrg_act  = 1'b0;
        fl_act   = 1'b0;
        case (r_state)
            srma_pkg::S_LOAD:  in_ready = 1'b1;
            srma_pkg::S_PRIME: ;
            srma_pkg::S_MERGE: mrg_act = 1'b1;
            srma_pkg::S_FLUSH: fl_act = out_free;
            default: ;
        endcase
    end

    assign o_in_ready = in_ready;

    // ---------------- next-value logic ----------------
    always_comb begin
        n_acnt   = r_acnt;
        n_bcnt   = r_bcnt;
        n_ai     = r_ai;
        n_bi     = r_bi;
        n_emit   = r_emit;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        n_ov     = r_ov && !i_out_ready;
        n_out    = r_out;

        if (we_a) n_acnt = r_acnt + 1'b1;
        if (we_b) n_bcnt = r_bcnt + 1'b1;

        if (mrg_go) begin
            if (take_a) n_ai = r_ai + 1'b1;
            if (take_b) n_bi = r_bi + 1'b1;
            if (nz) begin
                if (r_hold_v) begin
                    n_out = r_hold;
                    n_ov  = 1'b1;
                end
                n_hold_v = 1'b1;
                n_hold   = '{col: take_a ? rd_a.col : rd_b.col, val: sat_val,
                             present: 1'b1, last: 1'b0, cnt: r_emit + 1'b1};
                n_emit   = r_emit + 1'b1;
            end
        end

        if (fl_act) begin
            // close the row: held result goes out as last, or an empty marker
            if (r_hold_v) begin
                n_out      = r_hold;
                n_out.last = 1'b1;
            end else begin
                n_out = '{col: '0, val: '0, present: 1'b0, last: 1'b1, cnt: '0};
            end
            n_ov     = 1'b1;
            n_acnt   = '0;
            n_bcnt   = '0;
            n_ai     = '0;
            n_bi     = '0;
            n_emit   = '0;
            n_hold_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= srma_pkg::S_LOAD;
            r_acnt   <= '0;
            r_bcnt   <= '0;
            r_ai     <= '0;
            r_bi     <= '0;
            r_emit   <= '0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acnt   <= n_acnt;
            r_bcnt   <= n_bcnt;
            r_ai     <= n_ai;
            r_bi     <= n_bi;
            r_emit   <= n_emit;
            r_hold_v <= n_hold_v;
            r_ov     <= n_ov;
        end
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_out_valid   = r_ov;
    assign o_out_column  = r_out.col;
    assign o_out_value   = r_out.val;
    assign o_out_present = r_out.present;
    assign o_out_last    = r_out.last;
    assign o_out_count   = r_out.cnt;

    // ---------------- assertions ----------------
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ai <= r_acnt) && (r_bi <= r_bcnt))
        else $error("merge pointer ran past stored count");

    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_present) |-> (o_out_last && o_out_count == '0))
        else $error("empty-row beat malformed");

    a_hold_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> (r_hold.cnt != '0 && r_hold.cnt == r_emit))
        else $error("held result count out of step");

    a_row_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srma_pkg::S_FLUSH && out_free) |=>
            (r_acnt == '0 && r_bcnt == '0 && !r_hold_v && o_out_valid && o_out_last))
        else $error("row state not cleared after merge");

endmodule
`default_nettype wire

[test/tb_sparse_row_merge_add.sv]
// Self-checking bench for sparse_row_merge_add: directed table, then random row pairs.
module tb_sparse_row_merge_add;

    localparam int ROW_CAP      = 32;
    localparam int WANT_BEATS   = 310;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 20;
    localparam int STALL_LIMIT  = 3000;

    localparam int COL_W = srma_pkg::C_COL_W;
    localparam int VAL_W = srma_pkg::C_VAL_W;
    localparam int CNT_W = srma_pkg::C_CNT_W;
    localparam int NCOLS = srma_pkg::C_COLUMNS;

    localparam logic SRC_A    = 1'b0;
    localparam logic SRC_B    = 1'b1;
    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_SUB = 1'b1;

    localparam logic [2:0]  ADDR_SUBTRACT = {srma_pkg::C_IDX_SUBTRACT, 2'b00};
    localparam logic [31:0] V_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] V_MIN = 32'h8000_0000;

    typedef struct packed {
        logic             source;
        logic [COL_W-1:0] column;
        logic [VAL_W-1:0] value;
        logic             present;
        logic             last;
    } t_beat;

    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_beat             beat;
        bit                typed;
        srma_pkg::t_result want;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic             i_source = 1'b0;
    logic [COL_W-1:0] i_column = '0;
    logic [VAL_W-1:0] i_value = '0;
    logic             i_present = 1'b0;
    logic             i_last = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [COL_W-1:0] o_out_column;
    logic [VAL_W-1:0] o_out_value;
    logic             o_out_present;
    logic             o_out_last;
    logic [CNT_W-1:0] o_out_count;

    // predictor state
    srma_pkg::t_entry  row_a_q[$];
    srma_pkg::t_entry  row_b_q[$];
    logic              subtract_on = MODE_ADD;
    srma_pkg::t_result merge_out[$];
    srma_pkg::t_result merged_q[$];

    t_row  dir_rows[$];
    t_beat a_q[$];
    t_beat b_q[$];
    t_beat pair_q[$];

    int mismatches  = 0;
    int burst_left  = 0;
    int quiet_cycles = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int rx_run  = 0;
    bit rx_hold = 1'b1;

    sparse_row_merge_add DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_source      (i_source),
        .i_column      (i_column),
        .i_value       (i_value),
        .i_present     (i_present),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_column  (o_out_column),
        .o_out_value   (o_out_value),
        .o_out_present (o_out_present),
        .o_out_last    (o_out_last),
        .o_out_count   (o_out_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic srma_pkg::t_result res(input logic [COL_W-1:0] col,
                                              input logic [31:0] val,
                                              input logic pres, input logic lst,
                                              input logic [CNT_W-1:0] cnt);
        srma_pkg::t_result r;
        r.col     = col;
        r.val     = val;
        r.present = pres;
        r.last    = lst;
        r.cnt     = cnt;
        return r;
    endfunction

    function automatic t_beat mk(input logic src, input logic [COL_W-1:0] col,
                                 input logic [31:0] val, input logic pres, input logic lst);
        t_beat b;
        b.source  = src;
        b.column  = col;
        b.value   = val;
        b.present = pres;
        b.last    = lst;
        return b;
    endfunction

    function automatic void add_row(input t_row_kind kind, input t_beat b, input bit typed,
                                    input srma_pkg::t_result want);
        t_row r;
        r.kind  = kind;
        r.beat  = b;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return V_MAX;
        if (v < -64'sd2147483648)
            return V_MIN;
        return v[31:0];
    endfunction

    function automatic longint b_side(input logic [31:0] v);
        return subtract_on ? -longint'($signed(v)) : longint'($signed(v));
    endfunction

    // zero sums are dropped and do not advance the running count
    function automatic void push_entry(input logic [COL_W-1:0] col, input longint v);
        if (v == 0)
            return;
        merge_out.push_back(res(col, clamp32(v), 1'b1, 1'b0, CNT_W'(merge_out.size() + 1)));
    endfunction

    function automatic void merge_rows();
        int i;
        int j;
        i = 0;
        j = 0;
        merge_out.delete();
        while (i < row_a_q.size() && j < row_b_q.size()) begin
            if (row_a_q[i].col < row_b_q[j].col) begin
                push_entry(row_a_q[i].col, longint'($signed(row_a_q[i].val)));
                i++;
            end else if (row_b_q[j].col < row_a_q[i].col) begin
                push_entry(row_b_q[j].col, b_side(row_b_q[j].val));
                j++;
            end else begin
                push_entry(row_a_q[i].col,
                           longint'($signed(row_a_q[i].val)) + b_side(row_b_q[j].val));
                i++;
                j++;
            end
        end
        for (; i < row_a_q.size(); i++)
            push_entry(row_a_q[i].col, longint'($signed(row_a_q[i].val)));
        for (; j < row_b_q.size(); j++)
            push_entry(row_b_q[j].col, b_side(row_b_q[j].val));
        if (merge_out.size() == 0)
            merge_out.push_back(res('0, '0, 1'b0, 1'b1, '0));
        else
            merge_out[merge_out.size() - 1].last = 1'b1;
    endfunction

    function automatic void absorb_beat(input t_beat b);
        srma_pkg::t_entry e;
        merge_out.delete();
        if (b.present && b.column >= 1 && b.column <= NCOLS) begin
            e.col = b.column;
            e.val = b.value;
            if (b.source == SRC_A) begin
                if (row_a_q.size() < ROW_CAP)
                    row_a_q.push_back(e);
            end else if (row_b_q.size() < ROW_CAP) begin
                row_b_q.push_back(e);
            end
        end
        if (b.source == SRC_B && b.last) begin
            merge_rows();
            row_a_q.delete();
            row_b_q.delete();
        end
    endfunction

    function automatic void note_mismatch(input string why, input srma_pkg::t_result want,
                                          input srma_pkg::t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected col=%0d val=%h pres=%b last=%b cnt=%0d",
                     why, want.col, want.val, want.present, want.last, want.cnt);
            $display("    got col=%0d val=%h pres=%b last=%b cnt=%0d",
                     got.col, got.val, got.present, got.last, got.cnt);
        end
    endfunction

    // send one input beat in the current burst, then predict what it causes
    task automatic drive_beat(input t_beat b, input bit typed, input srma_pkg::t_result want);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            case ($urandom_range(0, 5))
                0, 1: gap = 0;
                5: gap = $urandom_range(8, 16);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_source   <= b.source;
        i_column   <= b.column;
        i_value    <= b.value;
        i_present  <= b.present;
        i_last     <= b.last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        burst_left--;
        absorb_beat(b);
        if (typed)
            merged_q.push_back(want);
        else
            foreach (merge_out[m])
                merged_q.push_back(merge_out[m]);
    endtask

    // register change only once the block has drained; read back straight after
    task automatic set_subtract(input logic mode);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (merged_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SUBTRACT;
        pwdata  <= {31'd0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        subtract_on = mode;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== {31'd0, mode}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("subtract_mode read back %h, wrote %0d", prdata, mode);
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return V_MAX;
            1: return V_MIN;
            2: return 32'd0;
            3: return 32'($urandom_range(0, 200)) - 32'd100;
            4: return 32'($urandom_range(0, 131072)) - 32'd65536;  // within +/-1.0
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(28, 35);  // around a full row, with overflow
        if (r <= 3)
            return 0;
        return $urandom_range(1, 6);
    endfunction

    // one A row then one B row, mostly sorted, with the odd broken sequence
    task automatic build_pair();
        int na;
        int nb;
        int step_max;
        int c;
        int r;
        int k;
        bit late;
        logic [31:0] va;
        logic [31:0] vb;
        logic [COL_W-1:0] tmp;
        t_beat x;
        a_q.delete();
        b_q.delete();
        pair_q.delete();
        late = 1'b0;
        na = pick_len();
        nb = pick_len();
        case ($urandom_range(0, 3))
            0: step_max = 1;
            1: step_max = 4;
            2: step_max = 40;
            default: step_max = 200;
        endcase
        if (na > 20 || nb > 20)
            step_max = 4;
        c = ($urandom_range(0, 7) == 0) ? $urandom_range(960, 1023) : $urandom_range(0, 20);
        while ((a_q.size() < na || b_q.size() < nb) && c < NCOLS) begin
            c += $urandom_range(1, step_max);
            if (c > NCOLS)
                break;
            r = $urandom_range(0, 2);
            if (a_q.size() >= na)
                r = 1;
            else if (b_q.size() >= nb)
                r = 0;
            va = pick_value();
            if (r != 1)
                a_q.push_back(mk(SRC_A, COL_W'(c), va, 1'b1, 1'b0));
            if (r != 0) begin
                // shared column: sometimes make the pair cancel in either mode
                if (r == 2 && $urandom_range(0, 2) == 0)
                    vb = $urandom_range(0, 1) ? va : -va;
                else
                    vb = pick_value();
                b_q.push_back(mk(SRC_B, COL_W'(c), vb, 1'b1, 1'b0));
            end
        end
        if (a_q.size() == 0)
            a_q.push_back(mk(SRC_A, COL_W'($urandom), $urandom, 1'b0, 1'b1));
        else
            a_q[a_q.size() - 1].last = 1'b1;
        if (b_q.size() == 0)
            b_q.push_back(mk(SRC_B, COL_W'($urandom), $urandom, 1'b0, 1'b1));
        else
            b_q[b_q.size() - 1].last = 1'b1;

        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
                0, 1: begin
                    // out-of-range column or an empty marker, never on the closing B beat
                    x = mk(1'($urandom_range(0, 1)), COL_W'($urandom), $urandom, 1'b0, 1'b0);
                    if ($urandom_range(0, 1)) begin
                        x.present = 1'b1;
                        x.column  = $urandom_range(0, 1) ? COL_W'(0)
                                    : COL_W'($urandom_range(NCOLS + 1, 2047));
                    end
                    if (x.source == SRC_A)
                        a_q.insert($urandom_range(0, a_q.size()), x);
                    else
                        b_q.insert($urandom_range(0, b_q.size() - 1), x);
                end
                2: if (a_q.size() >= 2) begin
                    k = $urandom_range(0, a_q.size() - 2);
                    tmp = a_q[k].column;
                    a_q[k].column = a_q[k + 1].column;
                    a_q[k + 1].column = tmp;
                end
                3: if (a_q.size() >= 2) begin
                    k = $urandom_range(0, a_q.size() - 2);
                    a_q[k + 1].column = a_q[k].column;
                end
                default: late = 1'b1;
            endcase
        end

        k = late ? $urandom_range(0, b_q.size() - 1) : 0;
        for (int n = 0; n < k; n++)
            pair_q.push_back(b_q[n]);
        foreach (a_q[n])
            pair_q.push_back(a_q[n]);
        for (int n = k; n < b_q.size(); n++)
            pair_q.push_back(b_q[n]);
    endtask

    // result side: stall pattern and checking
    always @(posedge i_clk) begin
        srma_pkg::t_result got;
        srma_pkg::t_result want;
        logic rdy;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = res(o_out_column, o_out_value, o_out_present, o_out_last, o_out_count);
            if (merged_q.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = merged_q.pop_front();
                if (got.col !== want.col || got.val !== want.val ||
                    got.present !== want.present || got.last !== want.last ||
                    got.cnt !== want.cnt)
                    note_mismatch("result mismatch", want, got);
            end
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        case (rx_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 4) == 0);
            default: begin
                if (rx_run == 0) begin
                    rx_run  = $urandom_range(2, 12);
                    rx_hold = !rx_hold;
                end
                rx_run--;
                rdy = rx_hold;
            end
        endcase
        i_out_ready <= rdy;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_row row;
        int sent;
        sent = 0;

        // add mode from reset
        add_row(ROW_BEAT, mk(SRC_B, 11'd0, 32'd0, 1'b0, 1'b1), 1'b1,
                res(11'd0, 32'd0, 1'b0, 1'b1, 7'd0));
        add_row(ROW_BEAT, mk(SRC_A, 11'd1, V_MAX, 1'b1, 1'b1), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_B, 11'd1, 32'd1, 1'b1, 1'b1), 1'b1,
                res(11'd1, V_MAX, 1'b1, 1'b1, 7'd1));
        add_row(ROW_BEAT, mk(SRC_A, 11'd1024, V_MIN, 1'b1, 1'b1), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_B, 11'd1024, V_MIN, 1'b1, 1'b1), 1'b1,
                res(11'd1024, V_MIN, 1'b1, 1'b1, 7'd1));
        // cancelling sum leaves an empty row
        add_row(ROW_BEAT, mk(SRC_A, 11'd5, 32'd100, 1'b1, 1'b1), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_B, 11'd5, 32'hFFFF_FF9C, 1'b1, 1'b1), 1'b1,
                res(11'd0, 32'd0, 1'b0, 1'b1, 7'd0));
        // columns outside 1..COLUMNS are ignored
        add_row(ROW_BEAT, mk(SRC_A, 11'd0, 32'd5, 1'b1, 1'b0), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_A, 11'd1025, 32'd5, 1'b1, 1'b0), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_A, 11'd2047, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_B, 11'd2047, 32'hFFFF_FFFF, 1'b0, 1'b1), 1'b1,
                res(11'd0, 32'd0, 1'b0, 1'b1, 7'd0));
        // lone stored zeros are not emitted
        add_row(ROW_BEAT, mk(SRC_A, 11'd3, 32'd0, 1'b1, 1'b1), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_B, 11'd7, 32'd0, 1'b1, 1'b1), 1'b1,
                res(11'd0, 32'd0, 1'b0, 1'b1, 7'd0));
        add_row(ROW_BEAT, mk(SRC_A, 11'd2, 32'd10, 1'b1, 1'b0), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_A, 11'd9, 32'hFFFF_FFFD, 1'b1, 1'b1), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_B, 11'd2, 32'd5, 1'b1, 1'b0), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_B, 11'd4, 32'd7, 1'b1, 1'b0), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_B, 11'd9, 32'd3, 1'b1, 1'b1), 1'b0, '0);
        // subtract mode: negating the most negative value saturates
        add_row(ROW_CFG, mk(SRC_A, '0, {31'd0, MODE_SUB}, 1'b0, 1'b0), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_B, 11'd1, V_MIN, 1'b1, 1'b1), 1'b1,
                res(11'd1, V_MAX, 1'b1, 1'b1, 7'd1));
        add_row(ROW_BEAT, mk(SRC_A, 11'd1, V_MIN, 1'b1, 1'b1), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_B, 11'd1, 32'd1, 1'b1, 1'b1), 1'b1,
                res(11'd1, V_MIN, 1'b1, 1'b1, 7'd1));
        // A beats after B beats, unsorted columns
        add_row(ROW_BEAT, mk(SRC_B, 11'd8, 32'd1, 1'b1, 1'b0), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_A, 11'd9, 32'd2, 1'b1, 1'b0), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_A, 11'd4, 32'd5, 1'b1, 1'b1), 1'b0, '0);
        add_row(ROW_BEAT, mk(SRC_B, 11'd3, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            if (row.kind == ROW_CFG) begin
                set_subtract(row.beat.value[0]);
            end else begin
                drive_beat(row.beat, row.typed, row.want);
                sent++;
            end
        end

        set_subtract(MODE_ADD);
        while (sent < WANT_BEATS) begin
            if ($urandom_range(0, 7) == 0)
                set_subtract(1'($urandom_range(0, 1)));
            build_pair();
            foreach (pair_q[n]) begin
                drive_beat(pair_q[n], 1'b0, '0);
                sent++;
            end
        end

        i_in_valid <= 1'b0;
        while (merged_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sparse_row_merge_add.f]
hdl/srma_pkg.sv
hdl/srma_ram.sv
hdl/sparse_row_merge_add.sv
test/tb_sparse_row_merge_add.sv
